FILE: sv/ultrasonic_ranging_controller_defines.svh
// ---------------------------------------------------------------------------
// Ultrasonic ranging controller assertion macros
// Concurrent check wrappers; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGING_CONTROLLER_DEFINES_SVH
`define ULTRASONIC_RANGING_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF

// Check under reset qualification
`define URC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds at every edge, reset included
`define URC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define URC_ASSERT(lbl, prop, msg)
`define URC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: sv/urc_pkg.sv
// ---------------------------------------------------------------------------
// Ultrasonic ranging controller package
// Phase codes, register indexes, widths and reset values.
// ---------------------------------------------------------------------------
package urc_pkg;

  // Widths fixed by the register map and result fields
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned TRIG_W      = 8;
  localparam int unsigned TIME_W      = 20;
  localparam int unsigned SCALE_W     = 16;
  localparam int unsigned DIST_W      = 16;
  localparam int unsigned PHASE_W     = 3;

  localparam int unsigned COUNT_WIDTH_DEF = 20;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_TRIG = 3'd1;
  localparam logic [PHASE_W-1:0] PH_RISE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_FALL = 3'd3;
  localparam logic [PHASE_W-1:0] PH_REST = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_W  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 3'd4;

  // Register reset values
  localparam logic [TRIG_W-1:0]  TRIG_W_RST  = 8'd10;
  localparam logic [TIME_W-1:0]  TIMEOUT_RST = 20'd60000;
  localparam logic [TIME_W-1:0]  PERIOD_RST  = 20'd50000;
  localparam logic [SCALE_W-1:0] SCALE_RST   = 16'd11141;

  localparam logic [DIST_W-1:0]  DIST_MAX    = 16'hFFFF;

endpackage

FILE: sv/ultrasonic_ranging_controller.sv
// ---------------------------------------------------------------------------
// Ultrasonic ranging controller
// Trigger/echo pulse-width ranger, one microsecond tick per input transaction.
// ---------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | in_echo_level
//  out     | out_valid / out_ready | trigger_out, distance_mm, distance_valid,
//          |                       | timed_out, phase
//  cfg     | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// One input transaction per cycle unless stalled; each gives one result
// transaction on the next cycle. The ranging state and the result flags
// update together on accept, so the state registers double as the result
// register. in_ready stays high while the result slot is empty or being
// taken. Synchronous active-low reset clears the phase, counters and distance.
// ---------------------------------------------------------------------------
`include "ultrasonic_ranging_controller_defines.svh"

module ultrasonic_ranging_controller #(
  parameter int unsigned COUNT_WIDTH = urc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [urc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input ticks
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_echo_level,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_trigger_out,
  output logic [urc_pkg::DIST_W-1:0]    out_distance_mm,
  output logic                          out_distance_valid,
  output logic                          out_timed_out,
  output logic [urc_pkg::PHASE_W-1:0]   out_phase
);
  import urc_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > TIME_W) ? COUNT_WIDTH : TIME_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
  endfunction

  // Configuration registers
  logic               enable_r;
  logic [TRIG_W-1:0]  trig_w_r;
  logic [TIME_W-1:0]  timeout_r;
  logic [TIME_W-1:0]  period_r;
  logic [SCALE_W-1:0] scale_r;

  // Ranging state
  logic [PHASE_W-1:0]     phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] wait_r, wait_nxt;
  logic [COUNT_WIDTH-1:0] width_r, width_nxt;
  logic                   echo_prev_r;
  logic [DIST_W-1:0]      dist_r, dist_nxt;
  logic                   dist_valid_r, dist_valid_nxt;
  logic                   tmo_r, tmo_nxt;
  logic                   out_valid_r;

  logic                   in_acc;
  logic [COUNT_WIDTH-1:0] wait_inc;
  logic [COUNT_WIDTH-1:0] width_inc;
  logic [CMP_W-1:0]       trig_lim;
  logic [DIST_W-1:0]      dist_scaled;

  // Write configuration registers, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      trig_w_r  <= TRIG_W_RST;
      timeout_r <= TIMEOUT_RST;
      period_r  <= PERIOD_RST;
      scale_r   <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:  enable_r  <= cfg_wdata[0];
        REG_TRIG_W:  trig_w_r  <= cfg_wdata[TRIG_W-1:0];
        REG_TIMEOUT: timeout_r <= cfg_wdata[TIME_W-1:0];
        REG_PERIOD:  period_r  <= cfg_wdata[TIME_W-1:0];
        REG_SCALE:   scale_r   <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign wait_inc  = sat_inc(wait_r);
  assign width_inc = sat_inc(width_r);
  assign trig_lim  = (trig_w_r == '0) ? CMP_W'(1) : CMP_W'(trig_w_r);

  urc_scale #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_scale (
    .width_cnt  (width_inc),
    .scale_q16  (scale_r),
    .distance_mm(dist_scaled)
  );

  // Advance the ranging sequence by one tick
  always_comb begin
    phase_nxt      = phase_r;
    wait_nxt       = wait_r;
    width_nxt      = width_r;
    dist_nxt       = dist_r;
    dist_valid_nxt = 1'b0;
    tmo_nxt        = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (enable_r) begin
          phase_nxt = PH_TRIG;
          wait_nxt  = COUNT_WIDTH'(1);
        end
      end
      PH_TRIG: begin
        if (CMP_W'(wait_r) >= trig_lim) begin
          phase_nxt = PH_RISE;
          wait_nxt  = '0;
        end else begin
          wait_nxt  = wait_inc;
        end
      end
      PH_RISE: begin
        wait_nxt = wait_inc;
        if (in_echo_level && !echo_prev_r) begin
          phase_nxt = PH_FALL;
          width_nxt = '0;
        end else if (CMP_W'(wait_inc) >= CMP_W'(timeout_r)) begin
          tmo_nxt   = 1'b1;
          phase_nxt = PH_IDLE;
          wait_nxt  = '0;
        end
      end
      PH_FALL: begin
        wait_nxt  = wait_inc;
        width_nxt = width_inc;
        if (!in_echo_level) begin
          dist_nxt       = dist_scaled;
          dist_valid_nxt = 1'b1;
          phase_nxt      = PH_REST;
          wait_nxt       = '0;
        end else if (CMP_W'(wait_inc) >= CMP_W'(timeout_r)) begin
          tmo_nxt   = 1'b1;
          phase_nxt = PH_IDLE;
          wait_nxt  = '0;
        end
      end
      PH_REST: begin
        wait_nxt = wait_inc;
        if (CMP_W'(wait_inc) >= CMP_W'(period_r)) begin
          phase_nxt = PH_IDLE;
          wait_nxt  = '0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        wait_nxt  = '0;
      end
    endcase
  end

  // Update state and result on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      wait_r       <= '0;
      width_r      <= '0;
      echo_prev_r  <= 1'b0;
      dist_r       <= '0;
      dist_valid_r <= 1'b0;
      tmo_r        <= 1'b0;
    end else if (in_acc) begin
      phase_r      <= phase_nxt;
      wait_r       <= wait_nxt;
      width_r      <= width_nxt;
      echo_prev_r  <= in_echo_level;
      dist_r       <= dist_nxt;
      dist_valid_r <= dist_valid_nxt;
      tmo_r        <= tmo_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_trigger_out    = (phase_r == PH_TRIG);
  assign out_distance_mm    = dist_r;
  assign out_distance_valid = dist_valid_r;
  assign out_timed_out      = tmo_r;
  assign out_phase          = phase_r;

  // Checks
  `URC_ASSERT(a_flags_excl, !(dist_valid_r && tmo_r), "distance and timeout both flagged")
  `URC_ASSERT(a_dist_rest, dist_valid_r |-> (phase_r == PH_REST), "distance outside rest")
  `URC_ASSERT(a_tmo_idle, tmo_r |-> (phase_r == PH_IDLE), "timeout not back to idle")
  `URC_ASSERT(a_fall_done,
    (in_acc && (phase_r == PH_FALL) && !in_echo_level) |=> dist_valid_r,
    "echo fall did not give a distance")
  `URC_ASSERT_ALWAYS(a_stall_hold,
    (rst_n && out_valid_r && !out_ready) |=> out_valid_r,
    "result dropped while stalled")

endmodule

FILE: sv/urc_scale.sv
// ---------------------------------------------------------------------------
// Echo width to distance scaler
// Multiplies the echo tick count by a Q16 scale and saturates to 16 bits.
// ---------------------------------------------------------------------------
module urc_scale #(
  parameter int unsigned COUNT_WIDTH = urc_pkg::COUNT_WIDTH_DEF
) (
  input  logic [COUNT_WIDTH-1:0]      width_cnt,
  input  logic [urc_pkg::SCALE_W-1:0] scale_q16,
  output logic [urc_pkg::DIST_W-1:0]  distance_mm
);
  import urc_pkg::*;

  localparam int unsigned PROD_W = COUNT_WIDTH + SCALE_W;

  logic [PROD_W-1:0]      prod;
  logic [COUNT_WIDTH-1:0] prod_int;

  // Multiply and drop the fraction
  assign prod     = PROD_W'(width_cnt) * PROD_W'(scale_q16);
  assign prod_int = prod[PROD_W-1:SCALE_W];

  // Clamp to the result range
  assign distance_mm = (prod_int > COUNT_WIDTH'(DIST_MAX)) ? DIST_MAX
                                                           : prod_int[DIST_W-1:0];

endmodule
